/* rtl/core/adcs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the adaptive dual core schedule unit.
// No dependencies.
package adcs_pkg;

   localparam int MAX_JOBS_DEF = 32;
   localparam logic [21:0] TIME_MAX = 22'h3FFFFF;

   localparam logic [1:0] CLS_SHORT  = 2'd0;
   localparam logic [1:0] CLS_MEDIUM = 2'd1;
   localparam logic [1:0] CLS_LONG   = 2'd2;

   localparam logic [1:0] CSR_QUANTUM = 2'd0;
   localparam logic [1:0] CSR_SHORT   = 2'd1;
   localparam logic [1:0] CSR_MEDIUM  = 2'd2;

   typedef struct packed {
      logic [15:0] burst_length;
      logic        last_job;
   } req_type;

   typedef struct packed {
      logic [5:0]  job_index;
      logic [21:0] wait_time;
      logic [21:0] turnaround_time;
      logic        core_used;
      logic [1:0]  policy_used;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [15:0] quantum;
      logic [15:0] short_limit;
      logic [15:0] medium_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0] burst;
      logic [15:0] remain;
      logic [21:0] start;
      logic [21:0] finish;
      logic        core;
   } rec_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SJ_RD,
      ST_SJ_GOT,
      ST_SK_RD,
      ST_SK_GOT,
      ST_SJ_WR,
      ST_RR_RD,
      ST_RR_GOT,
      ST_LG_RD,
      ST_LG_GOT,
      ST_OUT_RD,
      ST_OUT_GOT
   } state_type;

   function automatic logic [21:0] sat_add(input logic [21:0] a, input logic [21:0] b);
      logic [22:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[21:0];
   endfunction

   function automatic logic [1:0] class_of(input logic [15:0] b, input cfg_type c);
      if (b <= c.short_limit) return CLS_SHORT;
      if (b <= c.medium_limit) return CLS_MEDIUM;
      return CLS_LONG;
   endfunction

endpackage

/* rtl/core/adcs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual port RAM with registered read.
// No dependencies.
module adcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/adcs_csr.sv */
`timescale 1ns / 1ps
// Configuration registers: quantum and class limits.
// Depends on adcs_pkg.
module adcs_csr import adcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUANTUM: cfg_in.quantum = csr_wdata;
            CSR_SHORT:   cfg_in.short_limit = csr_wdata;
            CSR_MEDIUM:  cfg_in.medium_limit = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{quantum: 16'd4, short_limit: 16'd5, medium_limit: 16'd10};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

/* rtl/core/adcs_seq.sv */
`timescale 1ns / 1ps
// Load and schedule sequencer: walks the job table in RAM pass by pass.
// Depends on adcs_pkg and adcs_ram.
module adcs_seq import adcs_pkg::*; #(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, left_ff, left_in;
   logic [21:0]      acc_ff, acc_in, c0_ff, c0_in, c1_ff, c1_in;
   rec_type          reci_ff, reci_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   rec_type          ram_wdata, ram_rdata;

   adcs_ram #(.WIDTH($bits(rec_type)), .DEPTH(MAX_JOBS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rec_type     d;
      logic [15:0] q, sl, remn;
      logic [21:0] c1n, fin, ck, bext;
      logic        last_i, last_k, pick;
      logic [CNT_W-1:0] left_nx;

      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      reci_in      = reci_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = i_ff;
      ram_raddr    = i_ff;
      ram_wdata    = ram_rdata;

      d       = ram_rdata;
      q       = (cfg.quantum == 16'd0) ? 16'd1 : cfg.quantum;
      sl      = (d.remain < q) ? d.remain : q;
      remn    = d.remain - sl;
      c1n     = sat_add(c1_ff, {6'd0, sl});
      bext    = {6'd0, d.burst};
      last_i  = (CNT_W'(i_ff) + CNT_W'(1)) == cnt_ff;
      last_k  = (CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff;
      left_nx = left_ff;
      pick    = (c0_ff <= c1_ff) ? 1'b0 : 1'b1;
      ck      = pick ? c1_ff : c0_ff;
      fin     = sat_add(ck, bext);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CNT_MAX) begin
                  ram_we    = 1'b1;
                  ram_waddr = cnt_ff[IDX_W-1:0];
                  ram_wdata = '{burst: req_data.burst_length, default: '0};
                  cnt_in    = cnt_ff + CNT_W'(1);
               end
               if (req_data.last_job) begin
                  state_in = ST_SJ_RD;
                  i_in     = '0;
                  c0_in    = '0;
                  c1_in    = '0;
                  left_in  = '0;
               end
            end
         end
         ST_SJ_RD: begin
            ram_re   = 1'b1;
            state_in = ST_SJ_GOT;
         end
         ST_SJ_GOT: begin
            reci_in = d;
            case (class_of(d.burst, cfg))
               CLS_SHORT: begin
                  acc_in   = '0;
                  k_in     = '0;
                  c0_in    = sat_add(c0_ff, bext);
                  state_in = ST_SK_RD;
               end
               CLS_MEDIUM: begin
                  ram_we    = 1'b1;
                  ram_wdata = d;
                  ram_wdata.remain = d.burst;
                  left_nx   = left_ff + CNT_W'(1);
               end
               default: begin
                  left_nx = left_ff;
               end
            endcase
            left_in = left_nx;
            if (class_of(d.burst, cfg) != CLS_SHORT) begin
               if (last_i) begin
                  i_in     = '0;
                  state_in = (left_nx == '0) ? ST_LG_RD : ST_RR_RD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_SJ_RD;
               end
            end
         end
         ST_SK_RD: begin
            ram_re    = 1'b1;
            ram_raddr = k_ff;
            state_in  = ST_SK_GOT;
         end
         ST_SK_GOT: begin
            if (class_of(d.burst, cfg) == CLS_SHORT &&
                (d.burst < reci_ff.burst || (d.burst == reci_ff.burst && k_ff < i_ff))) begin
               acc_in = sat_add(acc_ff, bext);
            end
            if (last_k) begin
               state_in = ST_SJ_WR;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_SK_RD;
            end
         end
         ST_SJ_WR: begin
            ram_we    = 1'b1;
            ram_wdata = reci_ff;
            ram_wdata.start  = acc_ff;
            ram_wdata.finish = sat_add(acc_ff, {6'd0, reci_ff.burst});
            ram_wdata.core   = 1'b0;
            if (last_i) begin
               i_in     = '0;
               state_in = (left_ff == '0) ? ST_LG_RD : ST_RR_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_SJ_RD;
            end
         end
         ST_RR_RD: begin
            ram_re   = 1'b1;
            state_in = ST_RR_GOT;
         end
         ST_RR_GOT: begin
            if (class_of(d.burst, cfg) == CLS_MEDIUM && d.remain != 16'd0) begin
               c1_in     = c1n;
               ram_we    = 1'b1;
               ram_wdata = d;
               ram_wdata.remain = remn;
               if (remn == 16'd0) begin
                  ram_wdata.finish = c1n;
                  ram_wdata.start  = (c1n > bext) ? c1n - bext : 22'd0;
                  ram_wdata.core   = 1'b1;
                  left_nx          = left_ff - CNT_W'(1);
               end
            end
            left_in = left_nx;
            if (last_i) begin
               i_in     = '0;
               state_in = (left_nx == '0) ? ST_LG_RD : ST_RR_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_RR_RD;
            end
         end
         ST_LG_RD: begin
            ram_re   = 1'b1;
            state_in = ST_LG_GOT;
         end
         ST_LG_GOT: begin
            if (class_of(d.burst, cfg) == CLS_LONG) begin
               ram_we    = 1'b1;
               ram_wdata = d;
               ram_wdata.start  = ck;
               ram_wdata.finish = fin;
               ram_wdata.core   = pick;
               if (pick) begin
                  c1_in = fin;
               end else begin
                  c0_in = fin;
               end
            end
            if (last_i) begin
               i_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_LG_RD;
            end
         end
         ST_OUT_RD: begin
            ram_re   = 1'b1;
            state_in = ST_OUT_GOT;
         end
         ST_OUT_GOT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.job_index       = 6'(i_ff);
               rsp_in.wait_time       = d.start;
               rsp_in.turnaround_time = d.finish;
               rsp_in.core_used       = d.core;
               rsp_in.policy_used     = class_of(d.burst, cfg);
               rsp_in.last_result     = last_i;
               if (last_i) begin
                  cnt_in   = '0;
                  i_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         left_ff      <= '0;
         c0_ff        <= '0;
         c1_ff        <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         left_ff      <= left_in;
         c0_ff        <= c0_in;
         c1_ff        <= c1_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reci_ff <= reci_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

/* rtl/core/adaptive_dual_core_schedule_unit.sv */
`timescale 1ns / 1ps
// Adaptive dual core schedule unit: top level.
// Depends on adcs_pkg, adcs_csr, adcs_seq.
// Loading accepts one word per cycle. After the word marked last_job, the batch of N jobs
// is scheduled from a single job table RAM with registered read, each table access
// going through a read state and a got state: a classify/shortest-first pass, with a
// further table scan for each short job to sum the bursts ahead of it, round robin passes,
// as many as the largest medium burst needs quanta, a long job pass, and an output
// pass with one result word per job in load order. New words are stalled from the
// last_job word until the final result is issued.
module adaptive_dual_core_schedule_unit import adcs_pkg::*; #(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   cfg_type cfg;

   adcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adcs_seq #(.MAX_JOBS(MAX_JOBS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

/* rtl/core/adcs_checker.sv */
`timescale 1ns / 1ps
// Port checker for the adaptive dual core schedule unit, bound to the top level.
// Depends on adcs_pkg.
module adcs_checker import adcs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_sjf_core: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.policy_used == CLS_SHORT |-> !rsp_data.core_used)
      else $error("shortest first word not on core 0");

   a_rr_core: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.policy_used == CLS_MEDIUM |-> rsp_data.core_used)
      else $error("round robin word not on core 1");

   a_times: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.turnaround_time >= rsp_data.wait_time)
      else $error("turnaround below wait");

   a_batch_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_job |=> req_stall)
      else $error("input not stalled after last job");
endmodule

bind adaptive_dual_core_schedule_unit adcs_checker u_adcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
